// ----- hw/rtl/cgt_pkg.sv -----
// shared types and constants for the csr graph traversal engine
package cgt_pkg;

    localparam int MAX_VERTICES_DEF = 1024;
    localparam int MAX_EDGES_DEF    = 4096;
    localparam int CMD_W            = 2;
    localparam int FIELD_W          = 13;
    localparam int CNT_W            = 11;

    typedef enum logic [1:0] {
        CMD_WR_OFFSET = 2'd0,
        CMD_WR_TARGET = 2'd1,
        CMD_START     = 2'd2,
        CMD_NEXT      = 2'd3
    } cmd_t;

    localparam logic CFG_VERTEX_COUNT = 1'b0;
    localparam logic CFG_ORDER_MODE   = 1'b1;

    typedef struct packed {
        cmd_t               cmd;
        logic [FIELD_W-1:0] index;
        logic [FIELD_W-1:0] value;
    } cgt_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_TAKE,
        ST_TAKE_WAIT,
        ST_LO,
        ST_HI,
        ST_EDGE,
        ST_EDGE_WAIT,
        ST_MARK,
        ST_EMIT
    } eng_state_t;

endpackage

// ----- hw/rtl/cgt_front.sv -----
// front end: takes beats and queues them for the engine
module cgt_front
    import cgt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  cgt_op_t       in_op,
    output logic          q_valid,
    input  logic          q_ready,
    output cgt_op_t       q_op
);

    localparam int DEPTH = 2;

    cgt_op_t    slot_reg [DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'(DEPTH));
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_op     = slot_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_op;
        end
    end

endmodule

// ----- hw/rtl/cgt_engine.sv -----
// back end: table memories, worklist and the traversal sequencer
module cgt_engine
    import cgt_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = MAX_EDGES_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    output logic                       q_ready,
    input  cgt_op_t                    q_op,
    input  logic [CNT_W-1:0]           vertex_count,
    input  logic                       order_mode,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [9:0]                 out_vertex,
    output logic                       out_finished
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int OW = $clog2(MAX_VERTICES + 1);
    localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int PW = $clog2(MAX_EDGES + 1);
    localparam int LW = VW + 1;

    logic [FIELD_W-1:0] off_mem [MAX_VERTICES+1];
    logic [LW-1:0]      tgt_mem [MAX_EDGES];
    logic [VW-1:0]      wl_mem  [MAX_VERTICES];
    logic               mark_mem [MAX_VERTICES];

    eng_state_t         state_reg, state_next;
    logic [LW-1:0]      head_reg, head_next, tail_reg, tail_next;
    logic [VW-1:0]      v_reg, v_next;
    logic [FIELD_W-1:0] e_reg, e_next, hi_reg, hi_next;
    logic [VW-1:0]      clr_reg, clr_next;
    logic [VW-1:0]      seed_reg, seed_next;
    logic               seed_ok_reg, seed_ok_next;
    logic [LW-1:0]      t_reg, t_next;
    logic               ov_reg, ov_next;
    logic [9:0]         ovx_reg, ovx_next;
    logic               ofin_reg, ofin_next;

    logic [FIELD_W-1:0] off_rd;
    logic [LW-1:0]      tgt_rd;
    logic [VW-1:0]      wl_rd;
    logic               mark_rd;
    logic [OW-1:0]      off_addr;
    logic [VW-1:0]      mark_addr;
    logic [LW-1:0]      wl_addr;
    logic [LW:0]        nlive;

    logic               off_we, tgt_we, wl_we, mark_we, mark_wd;
    logic [VW-1:0]      mark_waddr;

    always_comb
    begin
        if (vertex_count == '0)
            nlive = (LW+1)'(1);
        else if ({1'b0, vertex_count} > (CNT_W+1)'(MAX_VERTICES) ||
                 CNT_W > LW)
            nlive = ({1'b0, vertex_count} > (CNT_W+1)'(MAX_VERTICES)) ?
                    (LW+1)'(MAX_VERTICES) : (LW+1)'(vertex_count);
        else
            nlive = (LW+1)'(vertex_count);
    end

    assign out_valid    = ov_reg;
    assign out_vertex   = ovx_reg;
    assign out_finished = ofin_reg;

    always_ff @(posedge clk)
    begin
        if (off_we)
            off_mem[OW'(q_op.index)] <= q_op.value;
        off_rd <= off_mem[off_addr];
    end

    // targets at or above the vertex range are kept as MAX_VERTICES
    always_ff @(posedge clk)
    begin
        if (tgt_we)
            tgt_mem[EW'(q_op.index)] <=
                ({1'b0, q_op.value} >= (FIELD_W+1)'(MAX_VERTICES)) ?
                LW'(MAX_VERTICES) : LW'(q_op.value);
        tgt_rd <= tgt_mem[EW'(e_reg)];
    end

    always_ff @(posedge clk)
    begin
        if (wl_we)
            wl_mem[VW'(tail_reg)] <= (state_reg == ST_IDLE) ? seed_reg : VW'(t_reg);
        wl_rd <= wl_mem[VW'(wl_addr)];
    end

    always_ff @(posedge clk)
    begin
        if (mark_we)
            mark_mem[mark_waddr] <= mark_wd;
        mark_rd <= mark_mem[mark_addr];
    end

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        v_next       = v_reg;
        e_next       = e_reg;
        hi_next      = hi_reg;
        clr_next     = clr_reg;
        seed_next    = seed_reg;
        seed_ok_next = seed_ok_reg;
        t_next       = t_reg;
        ov_next      = ov_reg && !out_ready;
        ovx_next     = ovx_reg;
        ofin_next    = ofin_reg;
        q_ready      = 1'b0;
        off_we       = 1'b0;
        tgt_we       = 1'b0;
        wl_we        = 1'b0;
        mark_we      = 1'b0;
        mark_wd      = 1'b0;
        mark_waddr   = clr_reg;
        off_addr     = OW'(v_reg);
        mark_addr    = VW'(tgt_rd);
        wl_addr      = order_mode ? tail_reg - LW'(1) : head_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (seed_ok_reg)
                begin
                    wl_we        = 1'b1;
                    mark_we      = 1'b1;
                    mark_wd      = 1'b1;
                    mark_waddr   = seed_reg;
                    tail_next    = LW'(1);
                    seed_ok_next = 1'b0;
                end
                else if (q_valid && !ov_reg)
                begin
                    q_ready = 1'b1;
                    case (q_op.cmd)
                        CMD_WR_OFFSET:
                            off_we = ({1'b0, q_op.index} <= (FIELD_W+1)'(MAX_VERTICES));
                        CMD_WR_TARGET:
                            tgt_we = ({1'b0, q_op.index} < (FIELD_W+1)'(MAX_EDGES));
                        CMD_START:
                        begin
                            head_next    = '0;
                            tail_next    = '0;
                            clr_next     = '0;
                            seed_next    = VW'(q_op.value);
                            seed_ok_next = ({1'b0, q_op.value} < (FIELD_W+1)'(nlive));
                            state_next   = ST_CLEAR;
                        end
                        CMD_NEXT:
                        begin
                            if (head_reg >= tail_reg)
                            begin
                                ov_next   = 1'b1;
                                ovx_next  = '0;
                                ofin_next = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_TAKE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                mark_we  = 1'b1;
                clr_next = clr_reg + VW'(1);
                if (clr_reg == VW'(MAX_VERTICES - 1))
                    state_next = ST_IDLE;
            end
            ST_TAKE:
            begin
                if (order_mode)
                    tail_next = tail_reg - LW'(1);
                else
                    head_next = head_reg + LW'(1);
                state_next = ST_TAKE_WAIT;
            end
            ST_TAKE_WAIT:
            begin
                v_next     = wl_rd;
                off_addr   = OW'(wl_rd);
                state_next = ST_LO;
            end
            ST_LO:
            begin
                off_addr   = OW'(v_reg) + OW'(1);
                e_next     = off_rd;
                state_next = ST_HI;
            end
            ST_HI:
            begin
                hi_next    = ({1'b0, off_rd} > (FIELD_W+1)'(MAX_EDGES)) ?
                             FIELD_W'(MAX_EDGES) : off_rd;
                state_next = ST_EDGE;
            end
            ST_EDGE:
            begin
                if (e_reg >= hi_reg)
                    state_next = ST_EMIT;
                else
                    state_next = ST_EDGE_WAIT;
            end
            ST_EDGE_WAIT:
            begin
                t_next     = tgt_rd;
                state_next = ST_MARK;
            end
            ST_MARK:
            begin
                if (t_reg < nlive[LW-1:0] && !mark_rd &&
                    tail_reg < LW'(MAX_VERTICES))
                begin
                    wl_we      = 1'b1;
                    mark_we    = 1'b1;
                    mark_wd    = 1'b1;
                    mark_waddr = VW'(t_reg);
                    tail_next  = tail_reg + LW'(1);
                end
                e_next     = e_reg + FIELD_W'(1);
                state_next = ST_EDGE;
            end
            ST_EMIT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    ovx_next   = 10'(v_reg);
                    ofin_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            head_reg    <= '0;
            tail_reg    <= '0;
            clr_reg     <= '0;
            seed_ok_reg <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            clr_reg     <= clr_next;
            seed_ok_reg <= seed_ok_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg    <= v_next;
        e_reg    <= e_next;
        hi_reg   <= hi_next;
        seed_reg <= seed_next;
        t_reg    <= t_next;
        ovx_reg  <= ovx_next;
        ofin_reg <= ofin_next;
    end

endmodule

// ----- hw/rtl/csr_graph_traversal.sv -----
// top level of the csr graph traversal engine
//   channel   direction  tuser           tdata
//   s_axis    in         command[1:0]    index[12:0] value[25:13]
//   m_axis    out        finished[0]     vertex[9:0]
//   cfg       in         -               0 vertex_count, 1 order_mode
// a load beat writes its table entry; a start then clears every mark entry and
// seeds the worklist. a next beat pops a vertex, reads its two offsets, then
// reads each edge's target and mark and pushes unmarked live targets; with an
// empty worklist it gives a finished result. the offset, target and mark memories
// have registered reads. after reset the mark memory is cleared; only the
// 2-beat queue takes beats then. a held result stalls the engine.
module csr_graph_traversal
    import cgt_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = MAX_EDGES_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // index, value
    input  logic [1:0]   s_axis_tuser,   // command
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [15:0]  m_axis_tdata,   // vertex
    output logic         m_axis_tuser,   // finished
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [10:0]  cfg_wdata
);

    logic [CNT_W-1:0] vcount_reg;
    logic             mode_reg;
    cgt_op_t          in_op, q_op;
    logic             q_valid, q_ready;
    logic [9:0]       vx;
    logic             fin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= CNT_W'(1);
            mode_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_VERTEX_COUNT)
                vcount_reg <= cfg_wdata;
            else
                mode_reg <= cfg_wdata[0];
        end
    end

    assign in_op.cmd    = cmd_t'(s_axis_tuser);
    assign in_op.index  = s_axis_tdata[12:0];
    assign in_op.value  = s_axis_tdata[25:13];
    assign m_axis_tdata = {6'd0, vx};
    assign m_axis_tuser = fin;

    cgt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_op    (in_op),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_op     (q_op)
    );

    cgt_engine #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_op         (q_op),
        .vertex_count (vcount_reg),
        .order_mode   (mode_reg),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_vertex   (vx),
        .out_finished (fin)
    );

endmodule

// ----- hw/rtl/cgt_checker.sv -----
// port-level checks for the csr graph traversal engine
module cgt_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");

    a_hold_user: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tuser))
        else $error("finished flag changed while stalled");

    a_fin_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[9:0] == 10'd0)
        else $error("finished with nonzero vertex");

    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:10] == 6'd0)
        else $error("pad bits set");

endmodule

bind csr_graph_traversal cgt_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- tb/tb.sv -----
// self-checking testbench for csr_graph_traversal: loads graphs, walks them, checks each visit
`timescale 1ns / 100ps

module tb;
    import cgt_pkg::*;

    localparam int NV       = 1024;
    localparam int NE       = 4096;
    localparam int PEND_N   = 4096;
    localparam int SETTLE   = 1200;
    localparam int IDLE_MAX = 20000;

    class traversal_tracker;
        bit [12:0] offsets[NV+1];
        bit        offset_set[NV+1];
        bit [12:0] targets[NE];
        bit        target_set[NE];
        bit        marks[NV];
        bit [9:0]  worklist[NV];
        int        head;
        int        tail;
        int        vcount = 1;
        bit        depth_first;
        bit [10:0] pend[PEND_N];
        int        pend_wr;
        int        pend_rd;
        int        seen;
        int        errors;

        function int live();
            if (vcount == 0) return 1;
            if (vcount > NV) return NV;
            return vcount;
        endfunction

        function void push(int v);
            if (tail < NV)
            begin
                worklist[tail] = 10'(v);
                tail++;
                marks[v] = 1;
            end
        endfunction

        function void record_visit(bit f, bit [9:0] v);
            pend[pend_wr % PEND_N] = {f, v};
            pend_wr++;
        endfunction

        // true when popping v reads only written table entries
        function bit vertex_ok(int v);
            int lo;
            int hi;
            if (!offset_set[v] || !offset_set[v+1]) return 0;
            lo = offsets[v];
            hi = offsets[v+1] > NE ? NE : offsets[v+1];
            for (int e = lo; e < hi; e++)
                if (!target_set[e]) return 0;
            return 1;
        endfunction

        function bit next_safe();
            if (head >= tail) return 1;
            return vertex_ok(depth_first ? worklist[tail-1] : worklist[head]);
        endfunction

        function void take_command(cmd_t c, int idx, int val);
            int n;
            int v;
            int lo;
            int hi;
            n = live();
            case (c)
                CMD_WR_OFFSET:
                    if (idx <= NV)
                    begin
                        offsets[idx] = 13'(val);
                        offset_set[idx] = 1;
                    end
                CMD_WR_TARGET:
                    if (idx < NE)
                    begin
                        targets[idx] = 13'(val);
                        target_set[idx] = 1;
                    end
                CMD_START:
                begin
                    foreach (marks[i]) marks[i] = 0;
                    head = 0;
                    tail = 0;
                    if (val < n) push(val);
                end
                default:
                    if (head >= tail)
                        record_visit(1'b1, 10'd0);
                    else
                    begin
                        if (depth_first)
                        begin
                            tail--;
                            v = worklist[tail];
                        end
                        else
                        begin
                            v = worklist[head];
                            head++;
                        end
                        lo = offsets[v];
                        hi = offsets[v+1] > NE ? NE : offsets[v+1];
                        for (int e = lo; e < hi; e++)
                            if (targets[e] < n && !marks[targets[e]]) push(targets[e]);
                        record_visit(1'b0, v[9:0]);
                    end
            endcase
        endfunction

        function void check_visit(logic [15:0] d, logic f);
            bit [10:0] want;
            seen++;
            if (pend_rd == pend_wr)
            begin
                errors++;
                $display("%0t: unexpected beat vertex %0d finished %0d", $time, d[9:0], f);
                return;
            end
            want = pend[pend_rd % PEND_N];
            pend_rd++;
            if (d[9:0] !== want[9:0])
            begin
                errors++;
                $display("%0t: vertex expected %0d actual %0d", $time, want[9:0], d[9:0]);
            end
            if (f !== want[10])
            begin
                errors++;
                $display("%0t: finished expected %0d actual %0d", $time, want[10], f);
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = 0;
    logic [1:0]  s_axis_tuser = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_we = 0;
    logic        cfg_index = 0;
    logic [10:0] cfg_wdata = 0;

    traversal_tracker trk = new;
    int burst_left;
    int graph_nv;
    int edge_lo;
    int edge_hi;
    int idle_cycles;
    int hold_left;
    int run_left;
    bit hold_done;
    bit choppy;

    csr_graph_traversal dut (.*);

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            trk.check_visit(m_axis_tdata, m_axis_tuser);
    end

    // receiver: runs of full rate and of random stalls, one long hold-off
    always @(posedge clk)
    begin
        if (!hold_done && trk.seen >= 60)
        begin
            hold_done = 1;
            hold_left = 3000;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 0;
        end
        else
        begin
            if (run_left == 0)
            begin
                run_left = $urandom_range(5, 60);
                choppy = $urandom_range(0, 2) != 0;
            end
            run_left--;
            m_axis_tready <= choppy ? ($urandom_range(0, 2) != 0) : 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_MAX)
        begin
            $display("csr_graph_traversal: mismatch");
            $finish;
        end
    end

    task send(cmd_t c, int idx, int val);
        bit [12:0] i13;
        bit [12:0] v13;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 3) != 0)
            begin
                s_axis_tvalid <= 0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
        burst_left--;
        i13 = 13'(idx);
        v13 = 13'(val);
        s_axis_tvalid <= 1;
        s_axis_tdata <= {6'b0, v13, i13};
        s_axis_tuser <= c;
        @(negedge clk);
        while (!s_axis_tready) @(negedge clk);
        @(posedge clk);
        trk.take_command(c, idx, val);
    endtask

    task drain();
        s_axis_tvalid <= 0;
        burst_left = 0;
        while (trk.pend_rd != trk.pend_wr) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task write_cfg(logic idx, int val);
        drain();
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_wdata <= 11'(val);
        @(posedge clk);
        cfg_we <= 0;
        if (idx == CFG_VERTEX_COUNT)
            trk.vcount = val;
        else
            trk.depth_first = val[0];
    endtask

    task build(int nv, int base);
        int o;
        int deg;
        graph_nv = nv;
        edge_lo = base;
        o = base;
        for (int v = 0; v < nv; v++)
        begin
            send(CMD_WR_OFFSET, v, o);
            deg = $urandom_range(0, 3);
            for (int k = 0; k < deg; k++)
                send(CMD_WR_TARGET, o + k,
                     $urandom_range(0, 3) != 0 ? $urandom_range(0, nv - 1)
                                               : $urandom_range(0, 8191));
            o += deg;
        end
        send(CMD_WR_OFFSET, nv, o);
        edge_hi = o;
    endtask

    task start_safe();
        int val;
        val = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8191)
                                          : $urandom_range(0, graph_nv - 1);
        if (val < trk.live() && !trk.vertex_ok(val))
            val = 8191;
        send(CMD_START, $urandom_range(0, 8191), val);
    endtask

    task run_random(int count);
        int r;
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                if (trk.next_safe())
                    send(CMD_NEXT, $urandom_range(0, 8191), $urandom_range(0, 8191));
                else
                    start_safe();
            end
            else if (r < 68)
                start_safe();
            else if (r < 78)
            begin
                if (r[0])
                    send(CMD_WR_OFFSET, $urandom_range(NV + 1, 8191), $urandom_range(0, 8191));
                else
                    send(CMD_WR_TARGET, $urandom_range(NE, 8191), $urandom_range(0, 8191));
            end
            else if (r < 93 && edge_hi > edge_lo)
                send(CMD_WR_TARGET, $urandom_range(edge_lo, edge_hi - 1),
                     $urandom_range(0, 1) ? $urandom_range(0, graph_nv - 1)
                                          : $urandom_range(0, 8191));
            else
                send(CMD_WR_OFFSET, $urandom_range(0, graph_nv), $urandom_range(edge_lo, edge_hi));
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // empty worklist, start out of range, ignored slots
        send(CMD_NEXT, 0, 0);
        send(CMD_START, 0, 3);
        send(CMD_NEXT, 8191, 8191);
        send(CMD_WR_OFFSET, NV + 1, 8191);
        send(CMD_WR_TARGET, NE, 8191);

        // vertex count zero, end offset saturated, out of range target
        write_cfg(CFG_VERTEX_COUNT, 0);
        write_cfg(CFG_ORDER_MODE, 1);
        send(CMD_WR_OFFSET, 0, 4094);
        send(CMD_WR_TARGET, 4094, 0);
        send(CMD_WR_TARGET, 4095, 5000);
        send(CMD_WR_OFFSET, 1, 8191);
        send(CMD_START, 0, 0);
        send(CMD_NEXT, 0, 0);
        send(CMD_NEXT, 0, 0);
        graph_nv = 1;
        edge_lo = 4094;
        edge_hi = 4096;
        run_random(20);

        write_cfg(CFG_VERTEX_COUNT, 6);
        write_cfg(CFG_ORDER_MODE, 0);
        build(6, 100);
        send(CMD_START, 0, 0);
        run_random(45);
        send(CMD_START, 0, 0);
        send(CMD_NEXT, 0, 0);
        write_cfg(CFG_ORDER_MODE, 1);
        run_random(45);

        write_cfg(CFG_VERTEX_COUNT, 1024);
        build(25, $urandom_range(0, 3900));
        run_random(50);

        write_cfg(CFG_VERTEX_COUNT, 2047);
        write_cfg(CFG_ORDER_MODE, 0);
        build(30, $urandom_range(0, 3900));
        run_random(50);

        write_cfg(CFG_VERTEX_COUNT, 40);
        build(40, $urandom_range(0, 3850));
        run_random(50);

        write_cfg(CFG_VERTEX_COUNT, 1);
        write_cfg(CFG_ORDER_MODE, 1);
        build(1, $urandom_range(0, 4000));
        run_random(35);

        write_cfg(CFG_VERTEX_COUNT, 12);
        write_cfg(CFG_ORDER_MODE, 0);
        build(12, $urandom_range(0, 3900));
        run_random(50);

        drain();
        if (trk.errors == 0)
            $display("csr_graph_traversal: match");
        else
            $display("csr_graph_traversal: mismatch");
        $finish;
    end
endmodule

// ----- filelist.f -----
hw/rtl/cgt_pkg.sv
hw/rtl/cgt_front.sv
hw/rtl/cgt_engine.sv
hw/rtl/csr_graph_traversal.sv
hw/rtl/cgt_checker.sv
tb/tb.sv
